FILE: rtl/qdd_pkg.sv
// Shared types, codes and the step table of the dual quadrature decoder.
package qdd_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_EDGE   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam logic REG_LEFT_INVERT  = 1'b0;
    localparam logic REG_RIGHT_INVERT = 1'b1;

    // Outcome of one AB transition
    typedef enum logic [1:0] {
        STEP_HOLD = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2,
        STEP_JUMP = 2'd3
    } step_t;

    // Indexed by {old A, old B, new A, new B}
    localparam step_t STEP_TABLE [16] = '{
        STEP_HOLD, STEP_DOWN, STEP_UP,   STEP_JUMP,
        STEP_UP,   STEP_HOLD, STEP_JUMP, STEP_DOWN,
        STEP_DOWN, STEP_JUMP, STEP_HOLD, STEP_UP,
        STEP_JUMP, STEP_UP,   STEP_DOWN, STEP_HOLD
    };

    typedef struct packed {
        kind_t       kind;
        logic        channel;
        logic [1:0]  edge_levels;
        logic [1:0]  left_levels_now;
        logic [1:0]  right_levels_now;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_delta;
        logic signed [15:0] right_delta;
        logic signed [31:0] left_total;
        logic signed [31:0] right_total;
        logic        [31:0] left_bad_steps;
        logic        [31:0] right_bad_steps;
    } out_item_t;

    // Per-channel command decoded from one request
    typedef struct packed {
        logic       edge_hit;
        logic       sample;
        logic       clear;
        logic [1:0] levels;
        logic       invert;
    } chan_ctrl_t;

    // Per-channel values reported with each result
    typedef struct packed {
        logic signed [15:0] delta;
        logic signed [31:0] total;
        logic        [31:0] bad;
    } chan_view_t;

endpackage

FILE: rtl/qdd_chan.sv
// One decoder channel: stored levels, pending count, delta, total and bad-step counter.
module qdd_chan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  qdd_pkg::chan_ctrl_t ctrl,
    output qdd_pkg::chan_view_t view_next
);

    logic        [1:0]  levels_reg,  levels_next;
    logic        [31:0] pending_reg, pending_next;
    logic        [31:0] bad_reg,     bad_next;
    logic signed [15:0] delta_reg,   delta_next;
    logic signed [31:0] total_reg,   total_next;
    qdd_pkg::step_t     step;

    // Look up the transition from stored to new levels
    assign step = qdd_pkg::STEP_TABLE[{levels_reg, ctrl.levels}];

    // Compute the state after this request
    always_comb
    begin
        levels_next  = levels_reg;
        pending_next = pending_reg;
        bad_next     = bad_reg;
        delta_next   = delta_reg;
        total_next   = total_reg;
        if (ctrl.edge_hit)
        begin
            levels_next = ctrl.levels;
            case (step)
                qdd_pkg::STEP_UP:   pending_next = pending_reg + 32'd1;
                qdd_pkg::STEP_DOWN: pending_next = pending_reg - 32'd1;
                qdd_pkg::STEP_JUMP: bad_next     = bad_reg + 32'd1;
                default:            pending_next = pending_reg;
            endcase
        end
        else if (ctrl.sample)
        begin
            pending_next = '0;
            if (ctrl.invert)
            begin
                delta_next = 16'sd0 - $signed(pending_reg[15:0]);
                total_next = total_reg - $signed(pending_reg);
            end
            else
            begin
                delta_next = $signed(pending_reg[15:0]);
                total_next = total_reg + $signed(pending_reg);
            end
        end
        else if (ctrl.clear)
        begin
            levels_next  = ctrl.levels;
            pending_next = '0;
            bad_next     = '0;
            delta_next   = '0;
            total_next   = '0;
        end
    end

    // Commit on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg  <= '0;
            pending_reg <= '0;
            bad_reg     <= '0;
            delta_reg   <= '0;
            total_reg   <= '0;
        end
        else if (advance)
        begin
            levels_reg  <= levels_next;
            pending_reg <= pending_next;
            bad_reg     <= bad_next;
            delta_reg   <= delta_next;
            total_reg   <= total_next;
        end
    end

    assign view_next.delta = delta_next;
    assign view_next.total = total_next;
    assign view_next.bad   = bad_next;

endmodule

FILE: rtl/dual_quadrature_decoder.sv
// Top level of the dual quadrature decoder: request register, channel units, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in      | input     | in_valid / in_stall  | in_item  (qdd_pkg::in_item_t)
//  out     | output    | out_valid / out_stall| out_item (qdd_pkg::out_item_t)
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One request per cycle sustained while out is not stalled; each accepted request is held in
// the request register, and the channel update (table lookup and one 32-bit add or subtract)
// then loads its outcome into the result register, which drives out_item.
// Reset clears all counters, stored levels and invert bits, and empties both registers.
// A stall on out holds the result; in stalls only while both registers are full.
module dual_quadrature_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  qdd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output qdd_pkg::out_item_t out_item,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic               cfg_data
);

    logic                s1_valid_reg,  s1_valid_next;
    qdd_pkg::in_item_t   s1_item_reg;
    logic                out_valid_reg, out_valid_next;
    qdd_pkg::out_item_t  out_item_reg;
    logic                left_invert_reg, right_invert_reg;
    logic                out_free, advance, in_take;
    qdd_pkg::chan_ctrl_t left_ctrl, right_ctrl;
    qdd_pkg::chan_view_t left_view, right_view;

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_invert_reg  <= 1'b0;
            right_invert_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == qdd_pkg::REG_LEFT_INVERT)
                left_invert_reg <= cfg_data;
            if (cfg_index == qdd_pkg::REG_RIGHT_INVERT)
                right_invert_reg <= cfg_data;
        end
    end

    // Hold the request and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_item;
        if (advance)
        begin
            out_item_reg.left_delta      <= left_view.delta;
            out_item_reg.right_delta     <= right_view.delta;
            out_item_reg.left_total      <= left_view.total;
            out_item_reg.right_total     <= right_view.total;
            out_item_reg.left_bad_steps  <= left_view.bad;
            out_item_reg.right_bad_steps <= right_view.bad;
        end
    end

    // Decode the request into per-channel commands
    always_comb
    begin
        left_ctrl.edge_hit  = (s1_item_reg.kind == qdd_pkg::KIND_EDGE) && !s1_item_reg.channel;
        right_ctrl.edge_hit = (s1_item_reg.kind == qdd_pkg::KIND_EDGE) && s1_item_reg.channel;
        left_ctrl.sample    = (s1_item_reg.kind == qdd_pkg::KIND_SAMPLE);
        right_ctrl.sample   = left_ctrl.sample;
        left_ctrl.clear     = (s1_item_reg.kind == qdd_pkg::KIND_CLEAR);
        right_ctrl.clear    = left_ctrl.clear;
        left_ctrl.levels    = left_ctrl.clear ? s1_item_reg.left_levels_now
                                              : s1_item_reg.edge_levels;
        right_ctrl.levels   = right_ctrl.clear ? s1_item_reg.right_levels_now
                                               : s1_item_reg.edge_levels;
        left_ctrl.invert    = left_invert_reg;
        right_ctrl.invert   = right_invert_reg;
    end

    qdd_chan u_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctrl      (left_ctrl),
        .view_next (left_view)
    );

    qdd_chan u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctrl      (right_ctrl),
        .view_next (right_view)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/qdd_checker.sv
// Port-level checks of the dual quadrature decoder, bound to the top level.
module qdd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input qdd_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input qdd_pkg::out_item_t out_item
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
    else $error("result changed while stalled");

    // Stall requests only when the result side is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("request stalled with room downstream");

    // A clear request reports all zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_item.kind == qdd_pkg::KIND_CLEAR)
        ##1 (!out_valid || !out_stall)
        |=> out_valid && out_item.left_delta == 16'sd0 && out_item.right_delta == 16'sd0
            && out_item.left_total == 32'sd0 && out_item.right_total == 32'sd0
            && out_item.left_bad_steps == 32'd0 && out_item.right_bad_steps == 32'd0)
    else $error("clear request did not report zero values");

endmodule

bind dual_quadrature_decoder qdd_checker u_qdd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

FILE: tb/sv/qdd_count_checker.sv
`timescale 1ns / 100ps
// Checker for the dual quadrature decoder: mirrors the counters and compares every result.
module qdd_count_checker
    import qdd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    input  logic      cfg_write,
    input  logic      cfg_index,
    input  logic      cfg_data,
    output int        mismatches,
    output int        waiting,
    output int        reports_checked
);

    // Mirror of the per-channel state, index 0 left, 1 right
    logic        invert_bit [2];
    logic [1:0]  last_ab    [2];
    logic [31:0] pending    [2];
    logic [31:0] bad_steps  [2];
    logic [15:0] delta      [2];
    logic [31:0] total      [2];

    out_item_t expected_reports [$];
    int        fail_total    = 0;
    int        checked_total = 0;
    int        queued_total  = 0;

    assign mismatches      = fail_total;
    assign waiting         = queued_total;
    assign reports_checked = checked_total;

    // Position of an AB pair along the Gray cycle 00, 01, 11, 10
    function automatic logic [1:0] gray_pos(logic [1:0] ab);
        case (ab)
            2'b00:   return 2'd0;
            2'b01:   return 2'd1;
            2'b11:   return 2'd2;
            default: return 2'd3;
        endcase
    endfunction

    // Forward along the cycle counts down, backward counts up, half a turn is illegal
    function automatic step_t classify_step(logic [1:0] old_ab, logic [1:0] new_ab);
        logic [1:0] diff;
        diff = gray_pos(new_ab) - gray_pos(old_ab);
        case (diff)
            2'd0:    return STEP_HOLD;
            2'd1:    return STEP_DOWN;
            2'd2:    return STEP_JUMP;
            default: return STEP_UP;
        endcase
    endfunction

    // Apply one request to the mirrored state and build the report it causes
    task automatic advance_counts(input in_item_t req, output out_item_t rep);
        int          ch;
        step_t       st;
        logic [31:0] v;
        case (req.kind)
            KIND_EDGE:
            begin
                ch = int'(req.channel);
                st = classify_step(last_ab[ch], req.edge_levels);
                last_ab[ch] = req.edge_levels;
                case (st)
                    STEP_JUMP: bad_steps[ch] = bad_steps[ch] + 32'd1;
                    STEP_UP:   pending[ch]   = pending[ch] + 32'd1;
                    STEP_DOWN: pending[ch]   = pending[ch] - 32'd1;
                    default:   ;
                endcase
            end
            KIND_SAMPLE:
            begin
                for (ch = 0; ch < 2; ch++)
                begin
                    v = pending[ch];
                    pending[ch] = '0;
                    if (invert_bit[ch])
                        v = 32'd0 - v;
                    delta[ch] = v[15:0];
                    total[ch] = total[ch] + v;
                end
            end
            KIND_CLEAR:
            begin
                for (ch = 0; ch < 2; ch++)
                begin
                    pending[ch]   = '0;
                    bad_steps[ch] = '0;
                    delta[ch]     = '0;
                    total[ch]     = '0;
                end
                last_ab[0] = req.left_levels_now;
                last_ab[1] = req.right_levels_now;
            end
            default: ;
        endcase
        rep.left_delta      = delta[0];
        rep.right_delta     = delta[1];
        rep.left_total      = total[0];
        rep.right_total     = total[1];
        rep.left_bad_steps  = bad_steps[0];
        rep.right_bad_steps = bad_steps[1];
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_total++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
        end
    endtask

    // Track register writes, predict on each accepted request, compare each result
    always @(posedge clk)
    begin : watch
        out_item_t want;
        out_item_t rep;
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                invert_bit[i] = 1'b0;
                last_ab[i]    = '0;
                pending[i]    = '0;
                bad_steps[i]  = '0;
                delta[i]      = '0;
                total[i]      = '0;
            end
            expected_reports.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_LEFT_INVERT)
                    invert_bit[0] = cfg_data;
                else
                    invert_bit[1] = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: result with no request outstanding, expected none actual %h",
                             $time, out_item);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    checked_total++;
                    check_field("left_delta", want.left_delta, out_item.left_delta);
                    check_field("right_delta", want.right_delta, out_item.right_delta);
                    check_field("left_total", want.left_total, out_item.left_total);
                    check_field("right_total", want.right_total, out_item.right_total);
                    check_field("left_bad_steps", want.left_bad_steps,
                                out_item.left_bad_steps);
                    check_field("right_bad_steps", want.right_bad_steps,
                                out_item.right_bad_steps);
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_counts(in_item, rep);
                expected_reports.push_back(rep);
            end
        end
        queued_total = expected_reports.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the dual quadrature decoder testbench: clock, reset, request stimulus and verdict.
module testbench;
    import qdd_pkg::*;

    localparam int IDLE_LIMIT       = 2000;
    localparam int RANDOM_PER_PHASE = 260;
    localparam int SWEEP_STEPS      = 40;
    localparam int LONG_HOLD        = 150;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      cfg_write;
    logic      cfg_index;
    logic      cfg_data;

    int mismatches;
    int waiting;
    int reports_checked;

    int gap_pct      = 0;
    int stall_pct    = 0;
    int hold_request = 0;
    int idle_cycles  = 0;

    int edges_sent   = 0;
    int samples_sent = 0;
    int clears_sent  = 0;
    int unused_sent  = 0;

    // Stimulus view of where each encoder sits on the Gray cycle
    logic [1:0] pin_pos  [2];
    logic       step_dir [2];

    dual_quadrature_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qdd_count_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_item        (out_item),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .waiting         (waiting),
        .reports_checked (reports_checked)
    );

    always #4 clk = ~clk;

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
            $display("dual_quadrature_decoder regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Drive the result stall: random, or held for a long stretch on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic logic [1:0] gray_levels(logic [1:0] pos);
        case (pos)
            2'd0:    return 2'b00;
            2'd1:    return 2'b01;
            2'd2:    return 2'b11;
            default: return 2'b10;
        endcase
    endfunction

    // Request of a given kind with every field the kind ignores randomized
    function automatic in_item_t noise_fields(kind_t k);
        in_item_t r;
        r.kind             = k;
        r.channel          = 1'($urandom_range(0, 1));
        r.edge_levels      = 2'($urandom_range(0, 3));
        r.left_levels_now  = 2'($urandom_range(0, 3));
        r.right_levels_now = 2'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic in_item_t edge_req(logic ch, logic [1:0] levels);
        in_item_t r;
        r             = noise_fields(KIND_EDGE);
        r.channel     = ch;
        r.edge_levels = levels;
        return r;
    endfunction

    function automatic in_item_t clear_req(logic [1:0] left_ab, logic [1:0] right_ab);
        in_item_t r;
        r                  = noise_fields(KIND_CLEAR);
        r.left_levels_now  = left_ab;
        r.right_levels_now = right_ab;
        return r;
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input in_item_t req);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        case (req.kind)
            KIND_EDGE:   edges_sent++;
            KIND_SAMPLE: samples_sent++;
            KIND_CLEAR:  clears_sent++;
            default:     unused_sent++;
        endcase
    endtask

    // Mostly legal Gray steps with drifting direction, plus noise, samples and clears
    task automatic pick_request(output in_item_t req);
        int roll;
        int ch;
        roll = $urandom_range(0, 99);
        ch   = $urandom_range(0, 1);
        if (roll < 68)
        begin
            if ($urandom_range(0, 15) == 0)
                step_dir[ch] = ~step_dir[ch];
            pin_pos[ch] = pin_pos[ch] + (step_dir[ch] ? 2'd1 : 2'd3);
            req = edge_req(ch[0], gray_levels(pin_pos[ch]));
        end
        else if (roll < 76)
        begin
            // any levels: holds and illegal jumps land here
            pin_pos[ch] = 2'($urandom_range(0, 3));
            req = edge_req(ch[0], gray_levels(pin_pos[ch]));
        end
        else if (roll < 88)
            req = noise_fields(KIND_SAMPLE);
        else if (roll < 93)
        begin
            pin_pos[0] = 2'($urandom_range(0, 3));
            pin_pos[1] = 2'($urandom_range(0, 3));
            req = clear_req(gray_levels(pin_pos[0]), gray_levels(pin_pos[1]));
        end
        else
            req = noise_fields(KIND_NONE);
    endtask

    // Write both invert registers back to back while the block is idle
    task automatic set_inverts(logic left_inv, logic right_inv);
        cfg_write <= 1'b1;
        cfg_index <= REG_LEFT_INVERT;
        cfg_data  <= left_inv;
        @(negedge clk);
        cfg_index <= REG_RIGHT_INVERT;
        cfg_data  <= right_inv;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait until every result has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        in_item_t req;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_write = 1'b0;
        cfg_index = REG_LEFT_INVERT;
        cfg_data  = 1'b0;
        pin_pos   = '{2'd0, 2'd0};
        step_dir  = '{1'b0, 1'b1};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_inverts(1'b0, 1'b0);

        // Directed: holds, both step directions and jumps on each channel, unused kind
        send_request(clear_req(2'b01, 2'b10));
        send_request(edge_req(1'b0, 2'b01));
        send_request(edge_req(1'b0, 2'b11));
        send_request(edge_req(1'b0, 2'b01));
        send_request(edge_req(1'b0, 2'b10));
        send_request(edge_req(1'b1, 2'b10));
        send_request(edge_req(1'b1, 2'b00));
        send_request(edge_req(1'b1, 2'b10));
        send_request(edge_req(1'b1, 2'b01));
        send_request(edge_req(1'b1, 2'b11));
        send_request(noise_fields(KIND_SAMPLE));
        send_request(noise_fields(KIND_NONE));
        send_request(edge_req(1'b0, 2'b00));
        send_request(edge_req(1'b0, 2'b01));
        send_request(noise_fields(KIND_SAMPLE));
        send_request(clear_req(2'b11, 2'b11));
        send_request(edge_req(1'b0, 2'b00));
        send_request(edge_req(1'b1, 2'b00));
        send_request(noise_fields(KIND_SAMPLE));
        send_request(noise_fields(KIND_NONE));
        send_request(clear_req(2'b00, 2'b00));

        // Sweep both channels steadily in opposite directions
        for (int i = 0; i < SWEEP_STEPS; i++)
        begin
            pin_pos[0] = pin_pos[0] + 2'd1;
            send_request(edge_req(1'b0, gray_levels(pin_pos[0])));
            pin_pos[1] = pin_pos[1] + 2'd3;
            send_request(edge_req(1'b1, gray_levels(pin_pos[1])));
        end
        send_request(noise_fields(KIND_SAMPLE));
        send_request(noise_fields(KIND_SAMPLE));

        // Hold off results while requests keep coming so the input backs up
        hold_request = LONG_HOLD;
        for (int i = 0; i < 40; i++)
        begin
            pick_request(req);
            send_request(req);
        end

        // Random phases, each under its own invert setting and idling mix
        for (int p = 0; p < 4; p++)
        begin
            settle();
            set_inverts(p[0], p[1]);
            case (p)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 67;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 67;
                end
                default:
                begin
                    gap_pct   = 27;
                    stall_pct = 27;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                pick_request(req);
                send_request(req);
            end
        end

        settle();
        repeat (4) @(negedge clk);
        $display("covered %0d requests: %0d edges, %0d samples, %0d clears, %0d unused kind",
                 edges_sent + samples_sent + clears_sent + unused_sent,
                 edges_sent, samples_sent, clears_sent, unused_sent);
        $display("%0d results checked over four invert settings, steady sweeps and a long hold",
                 reports_checked);
        if (mismatches == 0 && waiting == 0)
            $display("dual_quadrature_decoder regression: pass");
        else
            $display("dual_quadrature_decoder regression: fail");
        $finish;
    end

endmodule
